[rtl/core/trdl_pkg.sv]
// Package for the translation/rotation dominance lock: widths, codes, config type.
`timescale 1ns / 1ps
`default_nettype none
package trdl_pkg;

  localparam int AXIS_W = 10;
  localparam int REG_W  = 11;
  localparam int SUM_W  = 11;
  localparam int IDX_W  = 2;
  localparam int LANE_N = 3;

  // saturation bound applied to every axis
  localparam int FULL_SCALE = 350;

  localparam logic [IDX_W-1:0] REG_HYSTERESIS = 2'd0;
  localparam logic [IDX_W-1:0] REG_RELAX      = 2'd1;
  localparam logic [IDX_W-1:0] REG_ENGAGE     = 2'd2;

  localparam logic [REG_W-1:0] HYSTERESIS_RST = 11'd0;
  localparam logic [REG_W-1:0] RELAX_RST      = 11'd35;
  localparam logic [REG_W-1:0] ENGAGE_RST     = 11'd15;

  localparam logic [1:0] LOCK_NEUTRAL = 2'd0;
  localparam logic [1:0] LOCK_TRANS   = 2'd1;
  localparam logic [1:0] LOCK_ROT     = 2'd2;

  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic [REG_W-1:0] hysteresis;
    logic [REG_W-1:0] relax_threshold;
    logic [REG_W-1:0] engage_minimum;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/trdl_if.sv]
// Item channels: input motion frame and output locked frame.
`timescale 1ns / 1ps
`default_nettype none
interface trdl_in_if;
  logic valid;
  logic ready;
  logic signed [trdl_pkg::AXIS_W-1:0] trans_x;
  logic signed [trdl_pkg::AXIS_W-1:0] trans_y;
  logic signed [trdl_pkg::AXIS_W-1:0] trans_z;
  logic signed [trdl_pkg::AXIS_W-1:0] rot_x;
  logic signed [trdl_pkg::AXIS_W-1:0] rot_y;
  logic signed [trdl_pkg::AXIS_W-1:0] rot_z;

  modport source (output valid, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
                  input ready);
  modport sink   (input valid, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
                  output ready);
endinterface

interface trdl_out_if;
  logic valid;
  logic ready;
  logic signed [trdl_pkg::AXIS_W-1:0] out_trans_x;
  logic signed [trdl_pkg::AXIS_W-1:0] out_trans_y;
  logic signed [trdl_pkg::AXIS_W-1:0] out_trans_z;
  logic signed [trdl_pkg::AXIS_W-1:0] out_rot_x;
  logic signed [trdl_pkg::AXIS_W-1:0] out_rot_y;
  logic signed [trdl_pkg::AXIS_W-1:0] out_rot_z;
  logic [1:0]                         lock_state;

  modport source (output valid, out_trans_x, out_trans_y, out_trans_z,
                  out_rot_x, out_rot_y, out_rot_z, lock_state, input ready);
  modport sink   (input valid, out_trans_x, out_trans_y, out_trans_z,
                  out_rot_x, out_rot_y, out_rot_z, lock_state, output ready);
endinterface
`default_nettype wire

[rtl/core/trdl_lane.sv]
// Group lane: saturates three axes and registers them with their magnitude sum.
`timescale 1ns / 1ps
`default_nettype none
module trdl_lane (
  input  logic                clk,
  input  logic                load,
  input  trdl_pkg::axis_t     axis_in [trdl_pkg::LANE_N],
  output trdl_pkg::axis_t     axis_q  [trdl_pkg::LANE_N],
  output logic [trdl_pkg::SUM_W-1:0] sum_q
);

  localparam int WIDE_W = 17;
  localparam logic signed [WIDE_W-1:0] FS_POS = WIDE_W'(trdl_pkg::FULL_SCALE);
  localparam logic signed [WIDE_W-1:0] FS_NEG = -FS_POS;

  logic signed [WIDE_W-1:0]   wide [trdl_pkg::LANE_N];
  logic signed [WIDE_W-1:0]   sat  [trdl_pkg::LANE_N];
  logic [trdl_pkg::SUM_W-1:0] mag  [trdl_pkg::LANE_N];
  logic [trdl_pkg::SUM_W-1:0] sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < trdl_pkg::LANE_N; i++) begin
      wide[i] = WIDE_W'(axis_in[i]);
      if (wide[i] > FS_POS) begin
        sat[i] = FS_POS;
      end else if (wide[i] < FS_NEG) begin
        sat[i] = FS_NEG;
      end else begin
        sat[i] = wide[i];
      end
      mag[i]   = (sat[i] < 0) ? trdl_pkg::SUM_W'(-sat[i]) : trdl_pkg::SUM_W'(sat[i]);
      sum_next = sum_next + mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < trdl_pkg::LANE_N; i++) begin
        axis_q[i] <= trdl_pkg::AXIS_W'(sat[i]);
      end
      sum_q <= sum_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/trdl_merge.sv]
// Merge stage: lock state machine on the two group sums, muting and output register.
`timescale 1ns / 1ps
`default_nettype none
module trdl_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  trdl_pkg::cfg_t             cfg,
  input  logic [trdl_pkg::SUM_W-1:0] sum_t,
  input  logic [trdl_pkg::SUM_W-1:0] sum_r,
  input  trdl_pkg::axis_t            trans_in [trdl_pkg::LANE_N],
  input  trdl_pkg::axis_t            rot_in   [trdl_pkg::LANE_N],
  output trdl_pkg::axis_t            trans_q  [trdl_pkg::LANE_N],
  output trdl_pkg::axis_t            rot_q    [trdl_pkg::LANE_N],
  output logic [1:0]                 lock_state
);

  typedef enum logic [1:0] {
    NEUTRAL = trdl_pkg::LOCK_NEUTRAL,
    TRANS   = trdl_pkg::LOCK_TRANS,
    ROT     = trdl_pkg::LOCK_ROT
  } lock_t;

  localparam int CMP_W = trdl_pkg::SUM_W + 1;

  lock_t lock_mode, base, lock_next;
  logic  relax;
  logic [CMP_W-1:0] t_ext, r_ext, t_plus_h, r_plus_h;

  always_comb begin
    t_ext    = CMP_W'(sum_t);
    r_ext    = CMP_W'(sum_r);
    t_plus_h = t_ext + CMP_W'(cfg.hysteresis);
    r_plus_h = r_ext + CMP_W'(cfg.hysteresis);
    relax    = (sum_t < cfg.relax_threshold) && (sum_r < cfg.relax_threshold);
    base     = relax ? NEUTRAL : lock_mode;
    lock_next = base;
    case (base)
      TRANS: begin
        if (r_ext > t_plus_h) lock_next = ROT;
      end
      ROT: begin
        if (t_ext > r_plus_h) lock_next = TRANS;
      end
      default: begin
        lock_next = NEUTRAL;
        if (sum_r > sum_t && sum_r >= cfg.engage_minimum) begin
          lock_next = ROT;
        end else if (sum_t > sum_r && sum_t >= cfg.engage_minimum) begin
          lock_next = TRANS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode  <= NEUTRAL;
      lock_state <= trdl_pkg::LOCK_NEUTRAL;
    end else if (load) begin
      lock_mode  <= lock_next;
      lock_state <= lock_next;
      for (int i = 0; i < trdl_pkg::LANE_N; i++) begin
        trans_q[i] <= (lock_next == ROT)   ? '0 : trans_in[i];
        rot_q[i]   <= (lock_next == TRANS) ? '0 : rot_in[i];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/translation_rotation_dominance_lock.sv]
// Top level of the translation/rotation dominance lock.
//
// frame (sink): one six-axis motion item per handshake, accepted when
//   valid and ready are both high. result (source): one item per frame,
//   the axes of the non-dominant group zeroed, plus the lock state after
//   the frame (0 neutral, 1 translation, 2 rotation).
// wr_en/wr_index/wr_data: register writes (0 hysteresis, 1 relax threshold,
//   2 engage minimum); other indexes are ignored. Write only while idle.
// Path: an accepted frame is registered in the lane stage, then in the merge
//   stage's result register. Throughput: one item per cycle while result is
//   not stalled; the two group lanes saturate and sum in the first stage, the
//   merge stage updates the lock and registers the result in the second.
// When result is stalled the result register holds, the lane stage fills,
//   and frame.ready drops only while both stages are full; it rises again
//   in the same cycle that result.ready returns.
// Reset (rst, synchronous): both stages empty, lock neutral, registers
//   back to hysteresis 0, relax threshold 35, engage minimum 15.
`timescale 1ns / 1ps
`default_nettype none
module translation_rotation_dominance_lock (
  input  logic                         clk,
  input  logic                         rst,
  trdl_in_if.sink                      frame,
  trdl_out_if.source                   result,
  input  logic                         wr_en,
  input  logic [trdl_pkg::IDX_W-1:0]   wr_index,
  input  logic [trdl_pkg::REG_W-1:0]   wr_data
);

  trdl_pkg::cfg_t cfg;
  logic s1_valid, out_valid, advance, load_in, load_out;

  trdl_pkg::axis_t trans_in [trdl_pkg::LANE_N];
  trdl_pkg::axis_t rot_in   [trdl_pkg::LANE_N];
  trdl_pkg::axis_t trans_s1 [trdl_pkg::LANE_N];
  trdl_pkg::axis_t rot_s1   [trdl_pkg::LANE_N];
  trdl_pkg::axis_t trans_q  [trdl_pkg::LANE_N];
  trdl_pkg::axis_t rot_q    [trdl_pkg::LANE_N];
  logic [trdl_pkg::SUM_W-1:0] sum_t, sum_r;
  logic [1:0] lock_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hysteresis      <= trdl_pkg::HYSTERESIS_RST;
      cfg.relax_threshold <= trdl_pkg::RELAX_RST;
      cfg.engage_minimum  <= trdl_pkg::ENGAGE_RST;
    end else if (wr_en) begin
      case (wr_index)
        trdl_pkg::REG_HYSTERESIS: cfg.hysteresis      <= wr_data;
        trdl_pkg::REG_RELAX:      cfg.relax_threshold <= wr_data;
        trdl_pkg::REG_ENGAGE:     cfg.engage_minimum  <= wr_data;
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid || result.ready;
  assign load_out    = s1_valid && advance;
  assign frame.ready = !s1_valid || advance;
  assign load_in     = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (frame.ready) s1_valid <= frame.valid;
      if (advance) out_valid <= s1_valid;
    end
  end

  assign trans_in[0] = frame.trans_x;
  assign trans_in[1] = frame.trans_y;
  assign trans_in[2] = frame.trans_z;
  assign rot_in[0]   = frame.rot_x;
  assign rot_in[1]   = frame.rot_y;
  assign rot_in[2]   = frame.rot_z;

  trdl_lane u_lane_trans (
    .clk     (clk),
    .load    (load_in),
    .axis_in (trans_in),
    .axis_q  (trans_s1),
    .sum_q   (sum_t)
  );

  trdl_lane u_lane_rot (
    .clk     (clk),
    .load    (load_in),
    .axis_in (rot_in),
    .axis_q  (rot_s1),
    .sum_q   (sum_r)
  );

  trdl_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load_out),
    .cfg        (cfg),
    .sum_t      (sum_t),
    .sum_r      (sum_r),
    .trans_in   (trans_s1),
    .rot_in     (rot_s1),
    .trans_q    (trans_q),
    .rot_q      (rot_q),
    .lock_state (lock_q)
  );

  assign result.valid       = out_valid;
  assign result.out_trans_x = trans_q[0];
  assign result.out_trans_y = trans_q[1];
  assign result.out_trans_z = trans_q[2];
  assign result.out_rot_x   = rot_q[0];
  assign result.out_rot_y   = rot_q[1];
  assign result.out_rot_z   = rot_q[2];
  assign result.lock_state  = lock_q;

  a_no_code_three: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.lock_state != 2'b11)
    else $error("lock state code three on output");

  a_rot_mutes_trans: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.lock_state == trdl_pkg::LOCK_ROT |->
      result.out_trans_x == '0 && result.out_trans_y == '0 && result.out_trans_z == '0)
    else $error("translation not muted under rotation lock");

  a_trans_mutes_rot: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.lock_state == trdl_pkg::LOCK_TRANS |->
      result.out_rot_x == '0 && result.out_rot_y == '0 && result.out_rot_z == '0)
    else $error("rotation not muted under translation lock");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |-> !frame.ready)
    else $error("input taken while both stages are full and stalled");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ready |=> s1_valid)
    else $error("accepted item lost from lane stage");

endmodule
`default_nettype wire
